// ===== hdl/csed_pkg.sv =====
// ----------------------------------------------------------------------------
// csed_pkg
// Shared types, constants and arithmetic of the compass Sobel edge unit.
// ----------------------------------------------------------------------------
package csed_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int MIN_SIZE   = 3;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_POS_W = 11;
  localparam int SUM_W     = 11;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [7:0]              sample_t;
  typedef logic [23:0]             pixel_t;
  typedef sample_t [8:0]           window_t;   // index row*3 + col
  typedef logic signed [SUM_W-1:0] msum_t;
  typedef msum_t [3:0]             lane_sums_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic                 last;
  } meta_t;

  typedef struct packed {
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
  } lb_ctrl_t;

  // Four positive-lead compass masks; the negated four are covered by |s|.
  function automatic lane_sums_t mask_sums(input window_t p);
    msum_t      q [9];
    lane_sums_t s;
    for (int i = 0; i < 9; i++) begin
      q[i] = msum_t'({3'b000, p[i]});
    end
    s[0] = q[0] + (q[1] <<< 1) + q[2] - q[6] - (q[7] <<< 1) - q[8];
    s[1] = (q[0] <<< 1) + q[1] + q[3] - q[5] - q[7] - (q[8] <<< 1);
    s[2] = q[0] - q[2] + (q[3] <<< 1) - (q[5] <<< 1) + q[6] - q[8];
    s[3] = q[3] - q[1] - (q[2] <<< 1) - q[5] + (q[6] <<< 1) + q[7];
    return s;
  endfunction

  function automatic sample_t sat_abs(input msum_t s);
    logic [SUM_W-1:0] m;
    m = s[SUM_W-1] ? (~s + SUM_W'(1)) : s;
    return (m > SUM_W'(255)) ? 8'hFF : m[7:0];
  endfunction

  function automatic sample_t chan_edge(input lane_sums_t s);
    sample_t best;
    sample_t v;
    best = '0;
    for (int k = 0; k < 4; k++) begin
      v = sat_abs(s[k]);
      if (v > best) best = v;
    end
    return best;
  endfunction

endpackage

// ===== hdl/csed_if.sv =====
// ----------------------------------------------------------------------------
// csed interfaces
// Valid/ready channels for incoming pixels and outgoing edge results.
// ----------------------------------------------------------------------------
interface csed_pix_if import csed_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t blue_in;
  sample_t green_in;
  sample_t red_in;

  modport source (output valid, blue_in, green_in, red_in, input ready);
  modport sink   (input valid, blue_in, green_in, red_in, output ready);
endinterface

interface csed_edge_if import csed_pkg::*; ();
  logic                 valid;
  logic                 ready;
  sample_t              edge_blue;
  sample_t              edge_green;
  sample_t              edge_red;
  logic [OUT_POS_W-1:0] out_row;
  logic [OUT_POS_W-1:0] out_col;
  logic                 frame_last;

  modport source (output valid, edge_blue, edge_green, edge_red, out_row, out_col,
                  frame_last, input ready);
  modport sink   (input valid, edge_blue, edge_green, edge_red, out_row, out_col,
                  frame_last, output ready);
endinterface

// ===== hdl/csed_line_buf.sv =====
// ----------------------------------------------------------------------------
// csed_line_buf
// Upper and middle line stores; registered read, and write-back of the shifted
// column when that column moves on into the window.
// ----------------------------------------------------------------------------
module csed_line_buf import csed_pkg::*; (
  input  logic     clk,
  input  lb_ctrl_t ctrl,
  input  pixel_t   wr_pix,
  output pixel_t   upper,
  output pixel_t   middle
);

  pixel_t upper_mem [MAX_WIDTH];
  pixel_t mid_mem   [MAX_WIDTH];

  // middle still holds the value read for the column being written back
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      upper_mem[ctrl.wr_addr] <= middle;
      mid_mem[ctrl.wr_addr]   <= wr_pix;
    end
    if (ctrl.rd_en) begin
      upper  <= upper_mem[ctrl.rd_addr];
      middle <= mid_mem[ctrl.rd_addr];
    end
  end

endmodule

// ===== hdl/csed_lane.sv =====
// ----------------------------------------------------------------------------
// csed_lane
// One colour channel: four compass mask sums over the 3x3 window, registered.
// ----------------------------------------------------------------------------
module csed_lane import csed_pkg::*; (
  input  logic       clk,
  input  logic       load,
  input  window_t    pix,
  output lane_sums_t sums
);

  always_ff @(posedge clk) begin
    if (load) begin
      sums <= mask_sums(pix);
    end
  end

endmodule

// ===== hdl/csed_merge.sv =====
// ----------------------------------------------------------------------------
// csed_merge
// Saturated magnitude and maximum per channel, output register and handshake.
// ----------------------------------------------------------------------------
module csed_merge import csed_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  meta_t       meta,
  input  lane_sums_t  sums_blue,
  input  lane_sums_t  sums_green,
  input  lane_sums_t  sums_red,
  output logic        take,
  csed_edge_if.source result
);

  logic    out_valid;
  sample_t edge_b;
  sample_t edge_g;
  sample_t edge_r;
  meta_t   out_meta;

  assign take = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      edge_b   <= chan_edge(sums_blue);
      edge_g   <= chan_edge(sums_green);
      edge_r   <= chan_edge(sums_red);
      out_meta <= meta;
    end
  end

  assign result.valid      = out_valid;
  assign result.edge_blue  = edge_b;
  assign result.edge_green = edge_g;
  assign result.edge_red   = edge_r;
  assign result.out_row    = out_meta.row;
  assign result.out_col    = out_meta.col;
  assign result.frame_last = out_meta.last;

endmodule

// ===== hdl/compass_sobel_edge_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// compass_sobel_edge_rgb_unit
// Eight-direction compass Sobel edge detector on a raster RGB pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and returns, for
// every interior pixel, the largest saturated compass response of each channel
// with its row and column; border pixels give no result. A result passes the
// line store read register, lane sum register and output register after the
// request that completes its window, so the result for pixel (r-1, c-1)
// follows the request for pixel (r, c). Line stores are not cleared after
// reset; the first two rows of a frame fill them. Size registers take effect
// at once and must be written only while idle; the unit does not enforce it.
module compass_sobel_edge_rgb_unit import csed_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  csed_pix_if.sink             pixel,
  csed_edge_if.source          result
);

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;
  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [COL_W-1:0] c_eff;
  logic [ROW_W-1:0] r_eff;
  logic             accept;
  logic             en1;
  logic             en2;
  logic             en3;
  logic             adv1;

  logic             v1;
  pixel_t           s1_cur;
  logic [COL_W-1:0] s1_addr;
  logic             s1_emit;
  meta_t            s1_meta;
  logic             v2;
  meta_t            s2_meta;

  pixel_t           wcol [6];
  pixel_t           upper;
  pixel_t           middle;
  lb_ctrl_t         lb_ctrl;
  window_t          win [3];
  lane_sums_t       sums [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(image_width) < MIN_SIZE) begin
      w_eff = CFG_W'(MIN_SIZE);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (32'(image_height) < MIN_SIZE) begin
      h_eff = CFG_W'(MIN_SIZE);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
    w_m1  = COL_W'(w_eff - CFG_W'(1));
    h_m1  = ROW_W'(h_eff - CFG_W'(1));
    c_eff = (col_cnt > w_m1) ? w_m1 : col_cnt;
    r_eff = (row_cnt > h_m1) ? h_m1 : row_cnt;
  end

  // pipeline control: a stage moves when it is empty or its successor moves
  assign en2          = !v2 || en3;
  assign en1          = !v1 || en2;
  assign pixel.ready  = en1;
  assign accept       = pixel.valid && en1;
  assign adv1         = v1 && en2;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (c_eff == w_m1) begin
        col_cnt <= '0;
        row_cnt <= (r_eff == h_m1) ? '0 : r_eff + ROW_W'(1);
      end else begin
        col_cnt <= c_eff + COL_W'(1);
        row_cnt <= r_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= pixel.valid;
      if (en2) v2 <= v1 && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur       <= {pixel.red_in, pixel.green_in, pixel.blue_in};
      s1_addr      <= c_eff;
      s1_emit      <= (32'(r_eff) >= 2) && (32'(c_eff) >= 2);
      s1_meta.row  <= OUT_POS_W'(r_eff - ROW_W'(1));
      s1_meta.col  <= OUT_POS_W'(c_eff - COL_W'(1));
      s1_meta.last <= (r_eff == h_m1) && (c_eff == w_m1);
    end
    if (adv1 && s1_emit) begin
      s2_meta <= s1_meta;
    end
  end

  // window columns: [col*3 + row], column 0 oldest
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) wcol[i] <= '0;
    end else if (adv1) begin
      wcol[0] <= wcol[3];
      wcol[1] <= wcol[4];
      wcol[2] <= wcol[5];
      wcol[3] <= upper;
      wcol[4] <= middle;
      wcol[5] <= s1_cur;
    end
  end

  always_comb begin
    lb_ctrl.rd_en   = accept;
    lb_ctrl.rd_addr = c_eff;
    lb_ctrl.wr_en   = adv1;
    lb_ctrl.wr_addr = s1_addr;
  end

  csed_line_buf u_line_buf (
    .clk    (clk),
    .ctrl   (lb_ctrl),
    .wr_pix (s1_cur),
    .upper  (upper),
    .middle (middle)
  );

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    always_comb begin
      win[ch][0] = wcol[0][ch*8 +: 8];
      win[ch][1] = wcol[3][ch*8 +: 8];
      win[ch][2] = upper[ch*8 +: 8];
      win[ch][3] = wcol[1][ch*8 +: 8];
      win[ch][4] = wcol[4][ch*8 +: 8];
      win[ch][5] = middle[ch*8 +: 8];
      win[ch][6] = wcol[2][ch*8 +: 8];
      win[ch][7] = wcol[5][ch*8 +: 8];
      win[ch][8] = s1_cur[ch*8 +: 8];
    end

    csed_lane u_lane (
      .clk  (clk),
      .load (adv1 && s1_emit),
      .pix  (win[ch]),
      .sums (sums[ch])
    );
  end

  csed_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v2),
    .meta       (s2_meta),
    .sums_blue  (sums[0]),
    .sums_green (sums[1]),
    .sums_red   (sums[2]),
    .take       (en3),
    .result     (result)
  );

endmodule

// ===== hdl/csed_checker.sv =====
// ----------------------------------------------------------------------------
// csed_checker
// Port-level checks on the compass Sobel edge unit, bound to the top level.
// ----------------------------------------------------------------------------
module csed_checker import csed_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input sample_t              edge_blue,
  input sample_t              edge_green,
  input sample_t              edge_red,
  input logic [OUT_POS_W-1:0] out_row,
  input logic [OUT_POS_W-1:0] out_col,
  input logic                 frame_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable({edge_blue, edge_green, edge_red, out_row, out_col, frame_last}))
    else $error("result changed while stalled");

  a_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_row != '0 && out_col != '0)
    else $error("result on a border pixel");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused with empty output");

endmodule

bind compass_sobel_edge_rgb_unit csed_checker u_csed_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (pixel.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .edge_blue  (result.edge_blue),
  .edge_green (result.edge_green),
  .edge_red   (result.edge_red),
  .out_row    (result.out_row),
  .out_col    (result.out_col),
  .frame_last (result.frame_last)
);
